FILE: rtl/bfcc_pkg.sv
`default_nettype none
package bfcc_pkg;

  // Highest track that carries sectors; tracks above it count as empty.
  localparam int unsigned MAX_TRACK = 40;

  // Field widths of the entry and result channels.
  localparam int unsigned TRACK_W   = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned BAD_W     = 6;
  localparam int unsigned MAP_W     = 3 * BYTE_W;
  localparam int unsigned FMT_W     = 16;
  localparam int unsigned SIZE_W    = 18;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = SIZE_W;

  // Format identifier of a D64 image and the byte offset past the map sector.
  localparam logic [FMT_W-1:0]  FMT_D64       = 16'h0100;
  localparam logic [SIZE_W-1:0] MAP_END_BYTES = 18'd91648;
  localparam logic [FMT_W-1:0]  FMT_RESET     = 16'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET    = 18'd174848;

  // Saturation limits of the running totals.
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [BAD_W-1:0] BAD_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_FMT   = 2'd1,
    STATUS_SHORT_IMG = 2'd2
  } status_t;

  // One classified entry as it waits between the front and back ends.
  typedef struct packed {
    logic                first_entry;
    logic [TRACK_W-1:0]  track_number;
    logic [BYTE_W-1:0]   stored_free;
    logic [COUNT_W-1:0]  counted_free;
    logic [COUNT_W-1:0]  sectors;
    status_t             status;
  } cls_t;

  // Sectors per track of a D64 disk.
  function automatic logic [COUNT_W-1:0] track_sectors(input logic [TRACK_W-1:0] track);
    logic [COUNT_W-1:0] n;
    case (track) inside
      [6'd1 : 6'd17]:                      n = 5'd21;
      [6'd18 : 6'd24]:                     n = 5'd19;
      [6'd25 : 6'd30]:                     n = 5'd18;
      [6'd31 : TRACK_W'(MAX_TRACK)]:       n = 5'd17;
      default:                             n = 5'd0;
    endcase
    return n;
  endfunction

  // Set bits of one bitmap byte.
  function automatic logic [3:0] byte_ones(input logic [BYTE_W-1:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bfcc_ifs.sv
`default_nettype none
// Allocation-map entry channel.
interface bfcc_entry_if;
  import bfcc_pkg::*;
  logic               valid;
  logic               ready;
  logic               first_entry;
  logic [TRACK_W-1:0] track_number;
  logic [BYTE_W-1:0]  stored_free;
  logic [BYTE_W-1:0]  map_byte_low;
  logic [BYTE_W-1:0]  map_byte_mid;
  logic [BYTE_W-1:0]  map_byte_high;

  modport source (output valid, first_entry, track_number, stored_free,
                  map_byte_low, map_byte_mid, map_byte_high, input ready);
  modport sink   (input valid, first_entry, track_number, stored_free,
                  map_byte_low, map_byte_mid, map_byte_high, output ready);
endinterface

// Check result channel.
interface bfcc_result_if;
  import bfcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track_echo;
  logic [BYTE_W-1:0]  stored_echo;
  logic [COUNT_W-1:0] counted_free;
  logic               entry_valid;
  logic               needs_rewrite;
  logic [SUM_W-1:0]   block_total;
  logic [SUM_W-1:0]   free_total;
  logic [SUM_W-1:0]   used_total;
  logic [BAD_W-1:0]   bad_total;
  logic               corrupt_flag;
  logic [1:0]         status;

  modport source (output valid, track_echo, stored_echo, counted_free, entry_valid,
                  needs_rewrite, block_total, free_total, used_total, bad_total,
                  corrupt_flag, status, input ready);
  modport sink   (input valid, track_echo, stored_echo, counted_free, entry_valid,
                  needs_rewrite, block_total, free_total, used_total, bad_total,
                  corrupt_flag, status, output ready);
endinterface

// Configuration write channel.
interface bfcc_cfg_if;
  import bfcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bam_free_count_checker.sv
`default_nettype none
// Free-count checker for the allocation map of a D64 disk image.
// The entry channel takes one 4-byte map entry per request: a first-entry
// mark, the track number, the stored free count and three bitmap bytes.
// The result channel returns one request per entry, in order: the counted
// free sectors of the track, whether the stored count agrees, whether a
// repair must rewrite it, and the running block, free, used and bad totals.
// The configuration channel writes the format code (index 0) and the image
// size in bytes (index 1); it is always ready and should be used while idle.
// An entry is counted in the front end in the cycle it is accepted and is
// placed in a two-entry queue; the back end updates the totals and loads the
// result register from the head of the queue, so each entry waits in a slot.
// Throughput is one entry per cycle while the receiver takes every result.
// When the receiver stalls the result register holds, the queue fills, and
// the entry channel drops ready after three entries are held.
// Reset clears the totals, empties the queue and restores the format code to
// D64 and the image size to 174848 bytes.
module bam_free_count_checker (
  input  wire logic     clk,
  input  wire logic     rst,
  bfcc_entry_if.sink    entry,
  bfcc_result_if.source result,
  bfcc_cfg_if.sink      cfg
);
  import bfcc_pkg::*;

  cls_t push_data;
  logic push_valid;
  logic push_ready;
  cls_t pop_data;
  logic pop_valid;
  logic pop_ready;

  bfcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .entry      (entry),
    .cfg        (cfg),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  bfcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bfcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
`default_nettype wire

FILE: rtl/bfcc_front.sv
`default_nettype none
module bfcc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  bfcc_entry_if.sink        entry,
  bfcc_cfg_if.sink          cfg,
  output bfcc_pkg::cls_t    push_data,
  output logic              push_valid,
  input  wire logic         push_ready
);
  import bfcc_pkg::*;

  logic [FMT_W-1:0]   format_code;
  logic [SIZE_W-1:0]  image_bytes;
  status_t            status;
  logic [COUNT_W-1:0] sectors;
  logic [MAP_W-1:0]   mask;
  logic [MAP_W-1:0]   bits;
  logic [COUNT_W-1:0] counted;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_code <= FMT_RESET;
      image_bytes <= SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FORMAT_CODE: format_code <= cfg.data[FMT_W-1:0];
        REG_IMAGE_BYTES: image_bytes <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Image status; the format check takes precedence over the size check.
  always_comb begin
    if (format_code != FMT_D64) begin
      status = STATUS_BAD_FMT;
    end else if (image_bytes < MAP_END_BYTES) begin
      status = STATUS_SHORT_IMG;
    end else begin
      status = STATUS_OK;
    end
  end

  // Mask the bitmap to the track's sectors and count the free ones.
  assign sectors = (status == STATUS_OK) ? track_sectors(entry.track_number) : '0;
  assign mask    = MAP_W'(({{MAP_W{1'b0}}, 1'b1} << sectors) - 1'b1);
  assign bits    = {entry.map_byte_high, entry.map_byte_mid, entry.map_byte_low} & mask;
  assign counted = COUNT_W'(byte_ones(bits[7:0])) + COUNT_W'(byte_ones(bits[15:8]))
                 + COUNT_W'(byte_ones(bits[23:16]));

  // Hand the classified entry to the queue.
  assign entry.ready = push_ready;
  assign push_valid  = entry.valid;

  always_comb begin
    push_data.first_entry  = entry.first_entry;
    push_data.track_number = entry.track_number;
    push_data.stored_free  = entry.stored_free;
    push_data.counted_free = counted;
    push_data.sectors      = sectors;
    push_data.status       = status;
  end

endmodule
`default_nettype wire

FILE: rtl/bfcc_queue.sv
`default_nettype none
module bfcc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire bfcc_pkg::cls_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output bfcc_pkg::cls_t      pop_data
);
  import bfcc_pkg::*;

  cls_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Two-entry ring of classified entries.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bfcc_back.sv
`default_nettype none
module bfcc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire bfcc_pkg::cls_t pop_data,
  bfcc_result_if.source       result
);
  import bfcc_pkg::*;

  logic [SUM_W-1:0]   sum_total;
  logic [SUM_W-1:0]   sum_free;
  logic [BAD_W-1:0]   count_bad;
  logic [SUM_W-1:0]   sum_total_next;
  logic [SUM_W-1:0]   sum_free_next;
  logic [BAD_W-1:0]   count_bad_next;
  logic [SUM_W-1:0]   base_total;
  logic [SUM_W-1:0]   base_free;
  logic [BAD_W-1:0]   base_bad;
  logic [SUM_W:0]     add_total;
  logic [SUM_W:0]     add_free;
  logic               ok;
  logic               match;
  logic               out_valid;
  logic               take;

  assign take      = pop_valid && pop_ready;
  assign pop_ready = !out_valid || result.ready;

  // Running totals; a first-entry mark restarts them, a bad status leaves them.
  assign ok         = (pop_data.status == STATUS_OK);
  assign match      = ok && (pop_data.stored_free == BYTE_W'(pop_data.counted_free));
  assign base_total = pop_data.first_entry ? '0 : sum_total;
  assign base_free  = pop_data.first_entry ? '0 : sum_free;
  assign base_bad   = pop_data.first_entry ? '0 : count_bad;
  assign add_total  = {1'b0, base_total} + (SUM_W+1)'(pop_data.sectors);
  assign add_free   = {1'b0, base_free} + (SUM_W+1)'(pop_data.counted_free);

  always_comb begin
    sum_total_next = sum_total;
    sum_free_next  = sum_free;
    count_bad_next = count_bad;
    if (ok) begin
      sum_total_next = add_total[SUM_W] ? SUM_MAX : add_total[SUM_W-1:0];
      sum_free_next  = add_free[SUM_W] ? SUM_MAX : add_free[SUM_W-1:0];
      count_bad_next = (!match && base_bad != BAD_MAX) ? base_bad + 1'b1 : base_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_total <= '0;
      sum_free  <= '0;
      count_bad <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        sum_total <= sum_total_next;
        sum_free  <= sum_free_next;
        count_bad <= count_bad_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (take) begin
      result.track_echo    <= pop_data.track_number;
      result.stored_echo   <= pop_data.stored_free;
      result.counted_free  <= ok ? pop_data.counted_free : '0;
      result.entry_valid   <= match;
      result.needs_rewrite <= ok && !match;
      result.block_total   <= sum_total_next;
      result.free_total    <= sum_free_next;
      result.used_total    <= sum_total_next - sum_free_next;
      result.bad_total     <= count_bad_next;
      result.corrupt_flag  <= (count_bad_next != '0);
      result.status        <= pop_data.status;
    end
  end

  assign result.valid = out_valid;

endmodule
`default_nettype wire
